/* hdl/bust_pkg.sv */
// ----------------------------------------------------------------------------
// bust_pkg: shared types and constants for the bounded set table
// operation codes, transfer payload structs and default sizing
// ----------------------------------------------------------------------------
package bust_pkg;

  localparam int unsigned DefaultCapacity = 128;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned CountOutWidth   = 8;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                         kind;
    logic signed [ValueWidth-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic                      present;
    logic                      rejected;
    logic [CountOutWidth-1:0]  count;
  } out_item_t;

endpackage

/* hdl/bust_ram.sv */
// ----------------------------------------------------------------------------
// bust_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bust_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bust_ctrl.sv */
// ----------------------------------------------------------------------------
// bust_ctrl: operation sequencer for the bounded set table
// walks stored entries through the ram read port with one shared comparator,
// then moves the last entry into the hole left by a remove
// ----------------------------------------------------------------------------
module bust_ctrl #(
  parameter int unsigned Capacity = 128,
  parameter int unsigned CountW   = $clog2(Capacity + 1),
  parameter int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bust_pkg::in_item_t                 in_data_i,
  output logic                               rsp_valid_o,
  input  logic                               rsp_ready_i,
  output bust_pkg::out_item_t                rsp_o,
  output logic                               ram_we_o,
  output logic [AddrW-1:0]                   ram_waddr_o,
  output logic [bust_pkg::ValueWidth-1:0]    ram_wdata_o,
  output logic [AddrW-1:0]                   ram_raddr_o,
  input  logic [bust_pkg::ValueWidth-1:0]    ram_rdata_i
);

  import bust_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_MOVE,
    ST_DONE
  } state_e;

  localparam logic [CountW-1:0] CapCount = CountW'(Capacity);

  state_e                 state_q, state_d;
  kind_e                  kind_q, kind_d;
  logic [ValueWidth-1:0]  value_q, value_d;
  logic [CountW-1:0]      count_q, count_d;
  logic [CountW-1:0]      scan_q, scan_d;
  logic                   pend_q, pend_d;
  logic [AddrW-1:0]       pend_idx_q, pend_idx_d;
  logic [AddrW-1:0]       hit_idx_q, hit_idx_d;
  logic                   present_q, present_d;
  logic                   rejected_q, rejected_d;
  logic [CountW-1:0]      last_idx;
  logic                   hit;

  assign last_idx = count_q - CountW'(1);
  assign hit      = pend_q && (ram_rdata_i == value_q);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    value_d     = value_q;
    count_d     = count_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    hit_idx_d   = hit_idx_q;
    present_d   = present_q;
    rejected_d  = rejected_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q[AddrW-1:0];
    ram_wdata_o = in_data_i.value;
    ram_raddr_o = scan_q[AddrW-1:0];
    rsp_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d     = in_data_i.kind;
          value_d    = in_data_i.value;
          present_d  = 1'b0;
          rejected_d = 1'b0;
          scan_d     = '0;
          pend_d     = 1'b0;
          unique case (in_data_i.kind) inside
            KIND_CLEAR: begin
              count_d = '0;
              state_d = ST_DONE;
            end
            KIND_ADD: begin
              if (count_q < CapCount) begin
                ram_we_o = 1'b1;
                count_d  = count_q + CountW'(1);
              end else begin
                rejected_d = 1'b1;
              end
              state_d = ST_DONE;
            end
            KIND_REMOVE, KIND_QUERY: begin
              state_d = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          present_d = 1'b1;
          hit_idx_d = pend_idx_q;
          pend_d    = 1'b0;
          state_d   = (kind_q == KIND_REMOVE) ? ST_LAST : ST_DONE;
        end else if (scan_q < count_q) begin
          scan_d     = scan_q + CountW'(1);
          pend_d     = 1'b1;
          pend_idx_d = scan_q[AddrW-1:0];
        end else begin
          pend_d  = 1'b0;
          state_d = ST_DONE;
        end
      end
      ST_LAST: begin
        ram_raddr_o = last_idx[AddrW-1:0];
        state_d     = ST_MOVE;
      end
      ST_MOVE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = hit_idx_q;
        ram_wdata_o = ram_rdata_i;
        count_d     = last_idx;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      pend_q     <= 1'b0;
      present_q  <= 1'b0;
      rejected_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pend_q     <= pend_d;
      present_q  <= present_d;
      rejected_q <= rejected_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    value_q    <= value_d;
    scan_q     <= scan_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign rsp_o.present  = present_q;
  assign rsp_o.rejected = rejected_q;
  assign rsp_o.count    = CountOutWidth'(count_q);

endmodule

/* hdl/bounded_unordered_set_table.sv */
// ----------------------------------------------------------------------------
// bounded_unordered_set_table: fixed-capacity unordered value table
// clear, append, swap-remove and membership query on signed 32-bit values
// ----------------------------------------------------------------------------
// clear and add pass from the input transfer through the done state and the output register
// query scans the stored entries in order and stops early on a hit; remove on a hit
//   also goes through the last and move states to copy the last entry into the freed slot
// one item at a time, bound by the single ram read port scanning one entry a cycle
// reset clears the entry count and control state; ram contents are not cleared
// ----------------------------------------------------------------------------
module bounded_unordered_set_table #(
  parameter int unsigned Capacity = bust_pkg::DefaultCapacity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bust_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bust_pkg::out_item_t  out_data_o
);

  import bust_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic                   rsp_valid;
  logic                   rsp_ready;
  out_item_t              rsp;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [ValueWidth-1:0]  ram_wdata;
  logic [AddrW-1:0]       ram_raddr;
  logic [ValueWidth-1:0]  ram_rdata;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  bust_ctrl #(
    .Capacity (Capacity)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bust_ram #(
    .Width (ValueWidth),
    .Depth (Capacity)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register, refilled when empty or being drained
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_idle_no_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !rsp_valid)
    else $error("sequencer idle while holding a result");

  a_rsp_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && rsp_ready) |=> out_valid_o)
    else $error("result transfer did not load output register");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.present && out_data_o.rejected))
    else $error("present and rejected both set");

  a_reject_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rejected) |-> (out_data_o.count == CountOutWidth'(Capacity)))
    else $error("add rejected while table not full");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded unordered set table
// queued operations are driven with random gaps and output stalls; a shadow
// table predicts found, rejected and count for every transfer
// ----------------------------------------------------------------------------
module tb_top;
  import bust_pkg::*;

  localparam int TableDepth = DefaultCapacity;
  localparam int ModeFill   = 0;
  localparam int ModeDrain  = 1;
  localparam int ModeMixed  = 2;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  in_item_t              op_queue[$];
  out_item_t             outcome_queue[$];
  out_item_t             want_res;
  logic signed [31:0]    shadow_vals [TableDepth];
  int                    shadow_count = 0;
  logic signed [31:0]    value_pool [16];
  int unsigned           send_idle_pct  = 17;
  int unsigned           recv_stall_pct = 77;
  int                    err_cnt = 0;

  bounded_unordered_set_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic out_item_t apply_table_op(in_item_t op);
    out_item_t res;
    int hit;
    res = '0;
    hit = -1;
    if (op.kind == KIND_REMOVE || op.kind == KIND_QUERY) begin
      for (int i = 0; i < shadow_count; i++) begin
        if (hit < 0 && shadow_vals[i] == op.value) begin
          hit = i;
        end
      end
    end
    case (op.kind)
      KIND_CLEAR: begin
        shadow_count = 0;
      end
      KIND_ADD: begin
        if (shadow_count < TableDepth) begin
          shadow_vals[shadow_count] = op.value;
          shadow_count++;
        end else begin
          res.rejected = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          shadow_vals[hit] = shadow_vals[shadow_count-1];
          shadow_count--;
          res.present = 1'b1;
        end
      end
      default: begin
        res.present = (hit >= 0);
      end
    endcase
    res.count = CountOutWidth'(shadow_count);
    return res;
  endfunction

  task automatic queue_op(kind_e k, logic signed [31:0] v);
    in_item_t it;
    it.kind  = k;
    it.value = v;
    op_queue.push_back(it);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return value_pool[$urandom_range(15)];
    end else if (r < 72) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic kind_e pick_kind(int mode);
    int unsigned r;
    r = $urandom_range(99);
    if (mode == ModeFill) begin
      if (r < 75) return KIND_ADD;
      if (r < 85) return KIND_REMOVE;
      return KIND_QUERY;
    end else if (mode == ModeDrain) begin
      if (r < 10) return KIND_ADD;
      if (r < 65) return KIND_REMOVE;
      return KIND_QUERY;
    end
    if (r < 3) return KIND_CLEAR;
    if (r < 35) return KIND_ADD;
    if (r < 65) return KIND_REMOVE;
    return KIND_QUERY;
  endfunction

  task automatic wait_drained();
    while (op_queue.size() != 0 || in_valid_i || outcome_queue.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // driver: hold the payload until the transfer, then maybe idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        outcome_queue.push_back(apply_table_op(in_data_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= op_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_queue.size() == 0) begin
          report_mismatch("result transfer with no outcome pending");
        end else begin
          want_res = outcome_queue.pop_front();
          if (out_data_o.present !== want_res.present) begin
            report_mismatch($sformatf("present got %0b want %0b",
                                      out_data_o.present, want_res.present));
          end
          if (out_data_o.rejected !== want_res.rejected) begin
            report_mismatch($sformatf("rejected got %0b want %0b",
                                      out_data_o.rejected, want_res.rejected));
          end
          if (out_data_o.count !== want_res.count) begin
            report_mismatch($sformatf("count got %0d want %0d",
                                      out_data_o.count, want_res.count));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int seg_len;
    int seg_mode;
    int made;
    foreach (value_pool[i]) begin
      value_pool[i] = $urandom;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, duplicates, swap remove, stale entries after clear
    queue_op(KIND_CLEAR,  32'sd77);
    queue_op(KIND_QUERY,  32'sd0);
    queue_op(KIND_REMOVE, 32'sh8000_0000);
    queue_op(KIND_ADD,    32'sh8000_0000);
    queue_op(KIND_ADD,    32'sh7fff_ffff);
    queue_op(KIND_ADD,    32'sd0);
    queue_op(KIND_ADD,    -32'sd1);
    queue_op(KIND_ADD,    32'sh7fff_ffff);
    queue_op(KIND_QUERY,  32'sh8000_0000);
    queue_op(KIND_QUERY,  32'sd1);
    queue_op(KIND_QUERY,  -32'sd1);
    queue_op(KIND_REMOVE, 32'sh7fff_ffff);
    queue_op(KIND_QUERY,  32'sh7fff_ffff);
    queue_op(KIND_REMOVE, -32'sd1);
    queue_op(KIND_REMOVE, 32'sd12345);
    queue_op(KIND_REMOVE, 32'sh8000_0000);
    queue_op(KIND_CLEAR,  -32'sd1);
    queue_op(KIND_QUERY,  32'sh7fff_ffff);
    queue_op(KIND_REMOVE, 32'sd0);
    queue_op(KIND_ADD,    32'sh5555_5555);
    queue_op(KIND_QUERY,  32'shaaaa_aaaa);
    queue_op(KIND_ADD,    32'shaaaa_aaaa);
    queue_op(KIND_QUERY,  32'shaaaa_aaaa);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 77;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      // fill past capacity so adds get rejected
      queue_op(KIND_CLEAR, $urandom);
      repeat (TableDepth + 6) queue_op(KIND_ADD, pick_value());
      made = 0;
      while (made < 170) begin
        seg_mode = $urandom_range(ModeMixed);
        seg_len  = $urandom_range(40, 10);
        repeat (seg_len) queue_op(pick_kind(seg_mode), pick_value());
        made += seg_len;
      end
      wait_drained();
    end

    repeat (TableDepth + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
